[sv/ald_pkg.sv]
// shared types and constants for the associative lru tag directory
// no dependencies; imported by every module of the block
package ald_pkg;

    localparam int TAG_W   = 32;
    localparam int OP_W    = 2;
    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 64;

    typedef enum logic [OP_W-1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_INVAL = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE
    } state_t;

    // flags rippling down the cell chain
    typedef struct packed {
        logic hit;
        logic empty;
    } flags_t;

    // update broadcast to every cell
    typedef struct packed {
        logic             touch;
        logic             fill;
        logic             clear;
        logic [TAG_W-1:0] tag;
    } cmd_t;

    // counter increments
    typedef struct packed {
        logic rd_hit;
        logic rd_miss;
        logic wr_hit;
        logic wr_miss;
    } inc_t;

endpackage

[sv/ald_cell.sv]
// one directory cell: a slot tag, its recency rank and one stage of the selection chain
// depends on ald_pkg
module ald_cell #(
    parameter int NUM_SLOTS = 64,
    parameter int INDEX     = 0
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ald_pkg::cmd_t                    cmd,
    input  logic [$clog2(NUM_SLOTS)-1:0]     tgt_idx,
    input  logic [$clog2(NUM_SLOTS)-1:0]     tgt_rank,
    input  ald_pkg::flags_t                  flags_in,
    input  logic [$clog2(NUM_SLOTS)-1:0]     hit_idx_in,
    input  logic [$clog2(NUM_SLOTS)-1:0]     hit_rank_in,
    input  logic [$clog2(NUM_SLOTS)-1:0]     empty_idx_in,
    input  logic [$clog2(NUM_SLOTS)-1:0]     empty_rank_in,
    input  logic [$clog2(NUM_SLOTS)-1:0]     lru_idx_in,
    output ald_pkg::flags_t                  flags_out,
    output logic [$clog2(NUM_SLOTS)-1:0]     hit_idx_out,
    output logic [$clog2(NUM_SLOTS)-1:0]     hit_rank_out,
    output logic [$clog2(NUM_SLOTS)-1:0]     empty_idx_out,
    output logic [$clog2(NUM_SLOTS)-1:0]     empty_rank_out,
    output logic [$clog2(NUM_SLOTS)-1:0]     lru_idx_out
);
    import ald_pkg::*;

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam logic [IDX_W-1:0] MY_IDX    = IDX_W'(INDEX);
    localparam logic [IDX_W-1:0] LAST_RANK = IDX_W'(NUM_SLOTS - 1);

    logic [TAG_W-1:0] tag_reg,  tag_next;
    logic [IDX_W-1:0] rank_reg, rank_next;

    flags_t           flags_reg,      flags_next;
    logic [IDX_W-1:0] hit_idx_reg,    hit_idx_next;
    logic [IDX_W-1:0] hit_rank_reg,   hit_rank_next;
    logic [IDX_W-1:0] empty_idx_reg,  empty_idx_next;
    logic [IDX_W-1:0] empty_rank_reg, empty_rank_next;
    logic [IDX_W-1:0] lru_idx_reg,    lru_idx_next;

    logic match;
    logic is_empty;
    logic is_tgt;

    assign is_empty = (tag_reg == '0);
    assign match    = (tag_reg == cmd.tag) && !is_empty;
    assign is_tgt   = (tgt_idx == MY_IDX);

    // selection chain: lower cells override what came from above
    always_comb
    begin
        flags_next.hit   = flags_in.hit | match;
        flags_next.empty = flags_in.empty | is_empty;
        hit_idx_next     = match    ? MY_IDX   : hit_idx_in;
        hit_rank_next    = match    ? rank_reg : hit_rank_in;
        empty_idx_next   = is_empty ? MY_IDX   : empty_idx_in;
        empty_rank_next  = is_empty ? rank_reg : empty_rank_in;
        lru_idx_next     = (rank_reg == LAST_RANK) ? MY_IDX : lru_idx_in;
    end

    // state update broadcast
    always_comb
    begin
        tag_next  = tag_reg;
        rank_next = rank_reg;
        if (cmd.touch)
        begin
            if (is_tgt)
                rank_next = '0;
            else if (rank_reg < tgt_rank)
                rank_next = rank_reg + IDX_W'(1);
        end
        if (cmd.fill && is_tgt)
            tag_next = cmd.tag;
        if (cmd.clear && is_tgt)
            tag_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg  <= '0;
            rank_reg <= MY_IDX;
        end
        else
        begin
            tag_reg  <= tag_next;
            rank_reg <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flags_reg      <= flags_next;
        hit_idx_reg    <= hit_idx_next;
        hit_rank_reg   <= hit_rank_next;
        empty_idx_reg  <= empty_idx_next;
        empty_rank_reg <= empty_rank_next;
        lru_idx_reg    <= lru_idx_next;
    end

    assign flags_out      = flags_reg;
    assign hit_idx_out    = hit_idx_reg;
    assign hit_rank_out   = hit_rank_reg;
    assign empty_idx_out  = empty_idx_reg;
    assign empty_rank_out = empty_rank_reg;
    assign lru_idx_out    = lru_idx_reg;

endmodule

[sv/ald_counters.sv]
// read and write hit and miss counters, wrapping at 2^64
// depends on ald_pkg
module ald_counters (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ald_pkg::inc_t                 inc,
    output logic [ald_pkg::COUNT_W-1:0]   read_hits,
    output logic [ald_pkg::COUNT_W-1:0]   read_misses,
    output logic [ald_pkg::COUNT_W-1:0]   write_hits,
    output logic [ald_pkg::COUNT_W-1:0]   write_misses
);
    import ald_pkg::*;

    logic [COUNT_W-1:0] rd_hit_reg,  rd_hit_next;
    logic [COUNT_W-1:0] rd_miss_reg, rd_miss_next;
    logic [COUNT_W-1:0] wr_hit_reg,  wr_hit_next;
    logic [COUNT_W-1:0] wr_miss_reg, wr_miss_next;

    always_comb
    begin
        rd_hit_next  = rd_hit_reg  + COUNT_W'(inc.rd_hit);
        rd_miss_next = rd_miss_reg + COUNT_W'(inc.rd_miss);
        wr_hit_next  = wr_hit_reg  + COUNT_W'(inc.wr_hit);
        wr_miss_next = wr_miss_reg + COUNT_W'(inc.wr_miss);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_hit_reg  <= '0;
            rd_miss_reg <= '0;
            wr_hit_reg  <= '0;
            wr_miss_reg <= '0;
        end
        else
        begin
            rd_hit_reg  <= rd_hit_next;
            rd_miss_reg <= rd_miss_next;
            wr_hit_reg  <= wr_hit_next;
            wr_miss_reg <= wr_miss_next;
        end
    end

    assign read_hits    = rd_hit_reg;
    assign read_misses  = rd_miss_reg;
    assign write_hits   = wr_hit_reg;
    assign write_misses = wr_miss_reg;

endmodule

[sv/assoc_lru_tag_directory.sv]
// fully associative tag directory with true lru order, top level
// depends on ald_pkg, ald_cell and ald_counters
//
//  channel | signals                          | word
//  --------+----------------------------------+---------------------------------------
//  in      | in_valid, in_ready               | opcode, block_tag
//  out     | out_valid, out_ready             | slot, hit, not_found, bad_tag, counters
//
//  a word is accepted in the idle state, the search state lets the selection chain
//  ripple from the last cell down to cell 0, and the update state applies it
//  reset empties every slot, sets slot i at recency position i, zeroes counters
//  a new word is accepted while the previous result waits in the output register
//  the update cycle stalls until the output register is free
module assoc_lru_tag_directory #(
    parameter int NUM_SLOTS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ald_pkg::OP_W-1:0]      opcode,
    input  logic [ald_pkg::TAG_W-1:0]     block_tag,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ald_pkg::SLOT_W-1:0]    slot,
    output logic                          hit,
    output logic                          not_found,
    output logic                          bad_tag,
    output logic [ald_pkg::COUNT_W-1:0]   read_hits,
    output logic [ald_pkg::COUNT_W-1:0]   read_misses,
    output logic [ald_pkg::COUNT_W-1:0]   write_hits,
    output logic [ald_pkg::COUNT_W-1:0]   write_misses
);
    import ald_pkg::*;

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam logic [IDX_W-1:0] LAST_RANK = IDX_W'(NUM_SLOTS - 1);

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  cnt_reg,   cnt_next;
    logic [OP_W-1:0]   op_reg;
    logic [TAG_W-1:0]  qtag_reg;

    logic              out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0] slot_reg;
    logic              hit_reg;
    logic              nf_reg;
    logic              bad_reg;

    // chain wires; entry NUM_SLOTS is the idle input of the last cell
    flags_t            ch_flags      [NUM_SLOTS+1];
    logic [IDX_W-1:0]  ch_hit_idx    [NUM_SLOTS+1];
    logic [IDX_W-1:0]  ch_hit_rank   [NUM_SLOTS+1];
    logic [IDX_W-1:0]  ch_empty_idx  [NUM_SLOTS+1];
    logic [IDX_W-1:0]  ch_empty_rank [NUM_SLOTS+1];
    logic [IDX_W-1:0]  ch_lru_idx    [NUM_SLOTS+1];

    cmd_t              cmd;
    inc_t              inc;
    logic [IDX_W-1:0]  tgt_idx;
    logic [IDX_W-1:0]  tgt_rank;

    logic              accept;
    logic              fire;
    logic              is_bad;
    logic              is_rw;
    logic              is_inv;
    logic              found;
    logic [SLOT_W-1:0] res_slot;
    logic [IDX_W+SLOT_W-1:0] tgt_ext;

    assign ch_flags[NUM_SLOTS]      = '0;
    assign ch_hit_idx[NUM_SLOTS]    = '0;
    assign ch_hit_rank[NUM_SLOTS]   = '0;
    assign ch_empty_idx[NUM_SLOTS]  = '0;
    assign ch_empty_rank[NUM_SLOTS] = '0;
    assign ch_lru_idx[NUM_SLOTS]    = '0;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_SLOTS; gi++)
        begin : g_cell
            ald_cell #(
                .NUM_SLOTS (NUM_SLOTS),
                .INDEX     (gi)
            ) u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .cmd            (cmd),
                .tgt_idx        (tgt_idx),
                .tgt_rank       (tgt_rank),
                .flags_in       (ch_flags[gi+1]),
                .hit_idx_in     (ch_hit_idx[gi+1]),
                .hit_rank_in    (ch_hit_rank[gi+1]),
                .empty_idx_in   (ch_empty_idx[gi+1]),
                .empty_rank_in  (ch_empty_rank[gi+1]),
                .lru_idx_in     (ch_lru_idx[gi+1]),
                .flags_out      (ch_flags[gi]),
                .hit_idx_out    (ch_hit_idx[gi]),
                .hit_rank_out   (ch_hit_rank[gi]),
                .empty_idx_out  (ch_empty_idx[gi]),
                .empty_rank_out (ch_empty_rank[gi]),
                .lru_idx_out    (ch_lru_idx[gi])
            );
        end
    endgenerate

    // decision from the head of the chain
    assign found  = ch_flags[0].hit;
    assign is_bad = (qtag_reg == '0);
    assign is_rw  = !is_bad && ((op_reg == OP_READ) || (op_reg == OP_WRITE));
    assign is_inv = !is_bad && (op_reg == OP_INVAL);

    always_comb
    begin
        if (found)
        begin
            tgt_idx  = ch_hit_idx[0];
            tgt_rank = ch_hit_rank[0];
        end
        else if (ch_flags[0].empty)
        begin
            tgt_idx  = ch_empty_idx[0];
            tgt_rank = ch_empty_rank[0];
        end
        else
        begin
            tgt_idx  = ch_lru_idx[0];
            tgt_rank = LAST_RANK;
        end
    end

    // slot reports the low bits of the index
    assign tgt_ext  = {{SLOT_W{1'b0}}, tgt_idx};
    assign res_slot = (is_rw || (is_inv && found)) ? tgt_ext[SLOT_W-1:0] : '0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                    state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == LAST_RANK)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        in_ready = 1'b0;
        fire     = 1'b0;
        case (state_reg)
            ST_IDLE:   in_ready = 1'b1;
            ST_SEARCH: fire     = 1'b0;
            ST_UPDATE: fire     = !out_valid_reg || out_ready;
            default:   in_ready = 1'b0;
        endcase
    end

    assign accept = in_valid && in_ready;

    always_comb
    begin
        cmd.tag   = qtag_reg;
        cmd.touch = fire && is_rw;
        cmd.fill  = fire && is_rw && !found;
        cmd.clear = fire && is_inv && found;

        inc.rd_hit  = fire && is_rw && (op_reg == OP_READ)  && found;
        inc.rd_miss = fire && is_rw && (op_reg == OP_READ)  && !found;
        inc.wr_hit  = fire && is_rw && (op_reg == OP_WRITE) && found;
        inc.wr_miss = fire && is_rw && (op_reg == OP_WRITE) && !found;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode;
            qtag_reg <= block_tag;
        end
        if (fire)
        begin
            slot_reg <= res_slot;
            hit_reg  <= is_rw && found;
            nf_reg   <= is_inv && !found;
            bad_reg  <= is_bad;
        end
    end

    ald_counters u_counters (
        .clk          (clk),
        .rst_n        (rst_n),
        .inc          (inc),
        .read_hits    (read_hits),
        .read_misses  (read_misses),
        .write_hits   (write_hits),
        .write_misses (write_misses)
    );

    assign out_valid = out_valid_reg;
    assign slot      = slot_reg;
    assign hit       = hit_reg;
    assign not_found = nf_reg;
    assign bad_tag   = bad_reg;

endmodule

[sv/ald_checker.sv]
// port-level checks for the associative lru tag directory, bound to the top level
// depends on ald_pkg and assoc_lru_tag_directory
module ald_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [ald_pkg::OP_W-1:0]      opcode,
    input  logic [ald_pkg::TAG_W-1:0]     block_tag,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [ald_pkg::SLOT_W-1:0]    slot,
    input  logic                          hit,
    input  logic                          not_found,
    input  logic                          bad_tag,
    input  logic [ald_pkg::COUNT_W-1:0]   read_hits,
    input  logic [ald_pkg::COUNT_W-1:0]   read_misses,
    input  logic [ald_pkg::COUNT_W-1:0]   write_hits,
    input  logic [ald_pkg::COUNT_W-1:0]   write_misses
);
    import ald_pkg::*;

    // one word in flight: no second accept right after one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted twice in a row");

    // an offered word waits unchanged until it is taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(opcode) && $stable(block_tag))
        else $error("waiting input word changed");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(slot) && $stable(hit)
            && $stable(not_found) && $stable(bad_tag))
        else $error("stalled result changed");

    // counters may only move when a result is produced, so they hold while a result waits
    a_counters_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(read_hits) && $stable(read_misses)
            && $stable(write_hits) && $stable(write_misses))
        else $error("counters changed while result waits");

    a_bad_tag_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_tag |-> !hit && !not_found && (slot == '0))
        else $error("rejected tag reported a lookup");

endmodule

bind assoc_lru_tag_directory ald_checker u_ald_checker (.*);

[bench/assoc_lru_tag_directory_tb.sv]
`timescale 1ns / 1ps
// testbench for assoc_lru_tag_directory: directed rows, then random words of all four opcodes
// checked word by word against fixed row words or a tag directory predictor; depends on ald_pkg
module assoc_lru_tag_directory_tb;

    import ald_pkg::*;

    localparam int SLOTS        = 64;
    localparam int RANDOM_WORDS = 800;
    localparam int POOL_SIZE    = 96;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 500_000;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic               hit;
        logic               not_found;
        logic               bad_tag;
        logic [COUNT_W-1:0] read_hits;
        logic [COUNT_W-1:0] read_misses;
        logic [COUNT_W-1:0] write_hits;
        logic [COUNT_W-1:0] write_misses;
    } lookup_res_t;

    typedef struct packed {
        op_t              op;
        logic [TAG_W-1:0] tag;
        logic             fixed;
        lookup_res_t      res;
    } dir_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [OP_W-1:0]    opcode = '0;
    logic [TAG_W-1:0]   block_tag = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [SLOT_W-1:0]  slot;
    logic               hit;
    logic               not_found;
    logic               bad_tag;
    logic [COUNT_W-1:0] read_hits;
    logic [COUNT_W-1:0] read_misses;
    logic [COUNT_W-1:0] write_hits;
    logic [COUNT_W-1:0] write_misses;

    // predicted directory contents, position 0 is most recent
    logic [TAG_W-1:0]   dir_tags [SLOTS];
    logic [SLOT_W-1:0]  dir_order [SLOTS];
    logic [COUNT_W-1:0] rd_hit_cnt = '0;
    logic [COUNT_W-1:0] rd_miss_cnt = '0;
    logic [COUNT_W-1:0] wr_hit_cnt = '0;
    logic [COUNT_W-1:0] wr_miss_cnt = '0;

    lookup_res_t        pending_results [$];
    logic [TAG_W-1:0]   tag_pool [POOL_SIZE];
    int                 mismatch_count = 0;
    int                 cycle_count = 0;
    int                 hold_left = 0;
    bit                 quiet = 1'b0;
    bit                 hold_req = 1'b0;
    bit                 hold_done = 1'b0;

    // rows marked fixed carry their expected word; the others go to the predictor
    dir_row_t dir_rows [22] = '{
        '{OP_READ,  32'h0000_0000, 1'b1, '{6'd0, 1'b0, 1'b0, 1'b1, 64'd0, 64'd0, 64'd0, 64'd0}},
        '{OP_INVAL, 32'h0000_0000, 1'b1, '{6'd0, 1'b0, 1'b0, 1'b1, 64'd0, 64'd0, 64'd0, 64'd0}},
        '{OP_NONE,  32'h1234_5678, 1'b1, '{6'd0, 1'b0, 1'b0, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0}},
        '{OP_INVAL, 32'hFFFF_FFFF, 1'b1, '{6'd0, 1'b0, 1'b1, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0}},
        '{OP_READ,  32'hFFFF_FFFF, 1'b1, '{6'd0, 1'b0, 1'b0, 1'b0, 64'd0, 64'd1, 64'd0, 64'd0}},
        '{OP_READ,  32'hFFFF_FFFF, 1'b1, '{6'd0, 1'b1, 1'b0, 1'b0, 64'd1, 64'd1, 64'd0, 64'd0}},
        '{OP_WRITE, 32'h0000_0001, 1'b1, '{6'd1, 1'b0, 1'b0, 1'b0, 64'd1, 64'd1, 64'd0, 64'd1}},
        '{OP_WRITE, 32'h0000_0001, 1'b1, '{6'd1, 1'b1, 1'b0, 1'b0, 64'd1, 64'd1, 64'd1, 64'd1}},
        '{OP_WRITE, 32'h0000_0000, 1'b1, '{6'd0, 1'b0, 1'b0, 1'b1, 64'd1, 64'd1, 64'd1, 64'd1}},
        '{OP_INVAL, 32'hFFFF_FFFF, 1'b1, '{6'd0, 1'b0, 1'b0, 1'b0, 64'd1, 64'd1, 64'd1, 64'd1}},
        '{OP_READ,  32'h8000_0000, 1'b0, '0},
        '{OP_WRITE, 32'h0000_0002, 1'b0, '0},
        '{OP_NONE,  32'hFFFF_FFFF, 1'b0, '0},
        '{OP_INVAL, 32'h0000_0001, 1'b0, '0},
        '{OP_INVAL, 32'h0000_0001, 1'b0, '0},
        '{OP_READ,  32'h7FFF_FFFF, 1'b0, '0},
        '{OP_WRITE, 32'h8000_0000, 1'b0, '0},
        '{OP_READ,  32'hAAAA_AAAA, 1'b0, '0},
        '{OP_WRITE, 32'h5555_5555, 1'b0, '0},
        '{OP_INVAL, 32'h5555_5555, 1'b0, '0},
        '{OP_READ,  32'h5555_5555, 1'b0, '0},
        '{OP_NONE,  32'h0000_0000, 1'b0, '0}
    };

    assoc_lru_tag_directory #(
        .NUM_SLOTS(SLOTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .opcode(opcode),
        .block_tag(block_tag),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .slot(slot),
        .hit(hit),
        .not_found(not_found),
        .bad_tag(bad_tag),
        .read_hits(read_hits),
        .read_misses(read_misses),
        .write_hits(write_hits),
        .write_misses(write_misses)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            dir_tags[i]  = '0;
            dir_order[i] = i[SLOT_W-1:0];
        end
    end

    // applies one word to the predicted directory and returns the expected result
    function automatic lookup_res_t predict_access(op_t op, logic [TAG_W-1:0] tag);
        lookup_res_t r;
        int          s;
        int          p;
        r = '0;
        s = SLOTS;
        for (int i = SLOTS - 1; i >= 0; i--)
            if (dir_tags[i] == tag)
                s = i;
        if (tag == '0)
            r.bad_tag = 1'b1;
        else if (op == OP_READ || op == OP_WRITE)
        begin
            if (s < SLOTS)
            begin
                r.hit = 1'b1;
                if (op == OP_READ)
                    rd_hit_cnt++;
                else
                    wr_hit_cnt++;
            end
            else
            begin
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (dir_tags[i] == '0)
                        s = i;
                // no empty slot: evict the least recent
                if (s == SLOTS)
                    s = dir_order[SLOTS-1];
                dir_tags[s] = tag;
                if (op == OP_READ)
                    rd_miss_cnt++;
                else
                    wr_miss_cnt++;
            end
            p = 0;
            for (int i = SLOTS - 1; i >= 0; i--)
                if (dir_order[i] == s)
                    p = i;
            for (int i = p; i > 0; i--)
                dir_order[i] = dir_order[i-1];
            dir_order[0] = s[SLOT_W-1:0];
            r.slot = s[SLOT_W-1:0];
        end
        else if (op == OP_INVAL)
        begin
            if (s < SLOTS)
            begin
                dir_tags[s] = '0;
                r.slot = s[SLOT_W-1:0];
            end
            else
                r.not_found = 1'b1;
        end
        r.read_hits    = rd_hit_cnt;
        r.read_misses  = rd_miss_cnt;
        r.write_hits   = wr_hit_cnt;
        r.write_misses = wr_miss_cnt;
        return r;
    endfunction

    function automatic void check_field(string name, logic [COUNT_W-1:0] exp_val,
                                        logic [COUNT_W-1:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
            mismatch_count++;
        end
    endfunction

    function automatic void check_result();
        lookup_res_t want;
        if (pending_results.size() == 0)
        begin
            $display("%0t: unexpected word, expected none, actual slot %0d", $time, slot);
            mismatch_count++;
        end
        else
        begin
            want = pending_results.pop_front();
            check_field("slot", want.slot, slot);
            check_field("hit", want.hit, hit);
            check_field("not_found", want.not_found, not_found);
            check_field("bad_tag", want.bad_tag, bad_tag);
            check_field("read_hits", want.read_hits, read_hits);
            check_field("read_misses", want.read_misses, read_misses);
            check_field("write_hits", want.write_hits, write_hits);
            check_field("write_misses", want.write_misses, write_misses);
        end
    endfunction

    // mostly pool tags so lookups hit and the directory fills and evicts
    function automatic logic [TAG_W-1:0] pick_tag();
        int r;
        r = $urandom_range(99);
        if (r < 2)
            return '0;
        if (r < 5)
            return $urandom;
        if (r < 35)
            return tag_pool[$urandom_range(7)];
        return tag_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    task automatic send_word(input op_t op, input logic [TAG_W-1:0] tag, input bit fixed,
                             input lookup_res_t fixed_res);
        lookup_res_t predicted;
        if (!quiet && $urandom_range(99) < 9)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        block_tag <= tag;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = predict_access(op, tag);
        pending_results.push_back(fixed ? fixed_res : predicted);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // receiving side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_result();
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (hold_req && !hold_done)
            begin
                // long back-pressure so the block fills and stalls its input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
                out_ready <= quiet || ($urandom_range(99) >= 9);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int   r;
        int   inval_pct;
        op_t  op;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            tag_pool[i] = $urandom;
            if (tag_pool[i] == '0)
                tag_pool[i] = i + 1;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].op, dir_rows[i].tag, dir_rows[i].fixed, dir_rows[i].res);
        drain_results();

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            quiet = (n >= 500 && n < 620);
            if (n == 250)
                hold_req = 1'b1;
            if (n == 400)
                drain_results();
            // alternate fill-heavy and invalidate-heavy stretches
            inval_pct = (n % 200 < 120) ? 4 : 25;
            r = $urandom_range(99);
            if (r < 3)
                op = OP_NONE;
            else if (r < 3 + inval_pct)
                op = OP_INVAL;
            else if (r < 3 + inval_pct + (97 - inval_pct) / 2)
                op = OP_READ;
            else
                op = OP_WRITE;
            send_word(op, pick_tag(), 1'b0, '0);
        end
        drain_results();
        repeat (SLOTS + 4) @(posedge clk);

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
sv/ald_pkg.sv
sv/ald_cell.sv
sv/ald_counters.sv
sv/assoc_lru_tag_directory.sv
sv/ald_checker.sv
bench/assoc_lru_tag_directory_tb.sv
